/* hdl/hcc_pkg.sv */
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, constants and helpers for the hysteresis cooling controller.
// ----------------------------------------------------------------------------
package hcc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TARGET_TEMP = 3'd0,
    CFG_HYSTERESIS  = 3'd1,
    CFG_MIN_RUN_MS  = 3'd2,
    CFG_MIN_OFF_MS  = 3'd3,
    CFG_ENABLE      = 3'd4,
    CFG_MANUAL      = 3'd5
  } cfg_idx_e;

  // cooler command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OFF   = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  // input item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int TempW    = 12;
  localparam int TimeW    = 32;
  localparam int SetW     = 5;
  localparam int InDataW  = 48;
  localparam int OutDataW = 128;

  // statistic values when nothing has been seen yet
  localparam logic signed [TempW-1:0] StatMaxNone = -12'sd1000;
  localparam logic signed [TempW-1:0] StatMinNone = 12'sd1000;

  localparam logic [SetW-1:0] SetLow  = 5'd16;
  localparam logic [SetW-1:0] SetHigh = 5'd30;

  typedef struct packed {
    logic [8:0]       target_temp;
    logic [5:0]       hysteresis;
    logic [TimeW-1:0] min_run_ms;
    logic [TimeW-1:0] min_off_ms;
    logic             enable;
    logic             manual_override;
  } cfg_t;

  typedef struct packed {
    logic                    func;
    logic signed [TempW-1:0] temperature;
    logic [TimeW-1:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic signed [TempW-1:0] min_temp;
    logic signed [TempW-1:0] max_temp;
    logic [TimeW-1:0]        cycle_count;
    logic [TimeW-1:0]        total_off_ms;
    logic [TimeW-1:0]        total_run_ms;
    logic [SetW-1:0]         setpoint;
    cmd_e                    command;
    logic                    cooling;
  } result_t;

  // whole-degree setpoint: target / 10 by reciprocal (exact below 1024), clamped
  function automatic logic [SetW-1:0] calc_setpoint(input logic [8:0] target);
    logic [17:0] prod;
    logic [6:0]  quot;
    logic [SetW-1:0] sp;
    prod = 18'(target) * 18'd205;
    quot = prod[17:11];
    if (quot < 7'(SetLow)) begin
      sp = SetLow;
    end else if (quot > 7'(SetHigh)) begin
      sp = SetHigh;
    end else begin
      sp = quot[SetW-1:0];
    end
    return sp;
  endfunction

endpackage

/* hdl/hcc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hcc_cfg_regs
// Configuration register file written through a plain index/data port.
// ----------------------------------------------------------------------------
module hcc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hcc_pkg::CfgDataW-1:0]  cfg_data_i,
  output hcc_pkg::cfg_t                 cfg_o
);

  hcc_pkg::cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hcc_pkg::CFG_TARGET_TEMP: cfg_d.target_temp     = cfg_data_i[8:0];
        hcc_pkg::CFG_HYSTERESIS:  cfg_d.hysteresis      = cfg_data_i[5:0];
        hcc_pkg::CFG_MIN_RUN_MS:  cfg_d.min_run_ms      = cfg_data_i;
        hcc_pkg::CFG_MIN_OFF_MS:  cfg_d.min_off_ms      = cfg_data_i;
        hcc_pkg::CFG_ENABLE:      cfg_d.enable          = cfg_data_i[0];
        hcc_pkg::CFG_MANUAL:      cfg_d.manual_override = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp     <= 9'd240;
      cfg_q.hysteresis      <= 6'd10;
      cfg_q.min_run_ms      <= 32'd300000;
      cfg_q.min_off_ms      <= 32'd180000;
      cfg_q.enable          <= 1'b1;
      cfg_q.manual_override <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/hcc_ctrl.sv */
// ----------------------------------------------------------------------------
// hcc_ctrl
// On/off decision, timing totals and temperature extremes for one item.
// ----------------------------------------------------------------------------
module hcc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  hcc_pkg::item_t   item_i,
  input  hcc_pkg::cfg_t    cfg_i,
  output hcc_pkg::result_t result_o
);

  logic                                 cooling_q, cooling_d;
  logic [hcc_pkg::TimeW-1:0]            last_q, last_d;
  logic [hcc_pkg::TimeW-1:0]            run_q, run_d;
  logic [hcc_pkg::TimeW-1:0]            off_q, off_d;
  logic [hcc_pkg::TimeW-1:0]            cycles_q, cycles_d;
  logic signed [hcc_pkg::TempW-1:0]     max_q, max_d;
  logic signed [hcc_pkg::TempW-1:0]     min_q, min_d;

  logic                                 sample;
  logic                                 decide;
  logic                                 start;
  logic                                 stop;
  logic [hcc_pkg::TimeW-1:0]            elapsed;
  logic signed [hcc_pkg::TempW:0]       temp_x;
  logic signed [hcc_pkg::TempW:0]       upper;
  logic signed [hcc_pkg::TempW:0]       lower;

  // thresholds in 13-bit signed arithmetic, never overflow
  assign temp_x  = {item_i.temperature[hcc_pkg::TempW-1], item_i.temperature};
  assign upper   = $signed({4'b0, cfg_i.target_temp}) + $signed({7'b0, cfg_i.hysteresis});
  assign lower   = $signed({4'b0, cfg_i.target_temp}) - $signed({7'b0, cfg_i.hysteresis});
  assign elapsed = item_i.now_ms - last_q;

  // decision
  assign sample = (item_i.func == hcc_pkg::FUNC_SAMPLE);
  assign decide = sample && cfg_i.enable && !cfg_i.manual_override &&
                  (item_i.temperature != '0);
  assign start  = decide && (temp_x > upper) && !cooling_q && (elapsed >= cfg_i.min_off_ms);
  assign stop   = decide && (temp_x < lower) && cooling_q && (elapsed >= cfg_i.min_run_ms);

  // next state
  always_comb begin
    cooling_d = cooling_q;
    last_d    = last_q;
    run_d     = run_q;
    off_d     = off_q;
    cycles_d  = cycles_q;
    max_d     = max_q;
    min_d     = min_q;
    if (!sample) begin
      run_d    = '0;
      off_d    = '0;
      cycles_d = '0;
      max_d    = hcc_pkg::StatMaxNone;
      min_d    = hcc_pkg::StatMinNone;
    end else begin
      if (item_i.temperature > max_q) begin
        max_d = item_i.temperature;
      end
      if ((item_i.temperature < min_q) && (item_i.temperature > 12'sd0)) begin
        min_d = item_i.temperature;
      end
      if (start || stop) begin
        if (cooling_q) begin
          run_d    = run_q + elapsed;
          cycles_d = cycles_q + 32'd1;
        end else begin
          off_d = off_q + elapsed;
        end
        cooling_d = start;
        last_d    = item_i.now_ms;
      end
    end
  end

  // state registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooling_q <= 1'b0;
      last_q    <= '0;
      run_q     <= '0;
      off_q     <= '0;
      cycles_q  <= '0;
      max_q     <= hcc_pkg::StatMaxNone;
      min_q     <= hcc_pkg::StatMinNone;
    end else if (fire_i) begin
      cooling_q <= cooling_d;
      last_q    <= last_d;
      run_q     <= run_d;
      off_q     <= off_d;
      cycles_q  <= cycles_d;
      max_q     <= max_d;
      min_q     <= min_d;
    end
  end

  // result for this item
  always_comb begin
    result_o.cooling      = cooling_d;
    result_o.command      = start ? hcc_pkg::CMD_START :
                            (stop ? hcc_pkg::CMD_OFF : hcc_pkg::CMD_NONE);
    result_o.setpoint     = start ? hcc_pkg::calc_setpoint(cfg_i.target_temp) : '0;
    result_o.total_run_ms = run_d;
    result_o.total_off_ms = off_d;
    result_o.cycle_count  = cycles_d;
    result_o.max_temp     = max_d;
    result_o.min_temp     = min_d;
  end

endmodule

/* hdl/hysteresis_cooling_controller_core.sv */
// ----------------------------------------------------------------------------
// hysteresis_cooling_controller_core
// Two-state cooling thermostat with deadband, minimum run/off times and stats.
// ----------------------------------------------------------------------------
// datapath: an accepted item passes the input register, then decision logic
//   into the result register
// throughput: one item per cycle; stalls only when the result register is full
//   and not taken
// reset: asynchronous active low; cooler off, totals zero, extremes empty,
//   configuration registers at their default values
module hysteresis_cooling_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [hcc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [hcc_pkg::CfgDataW-1:0]    cfg_data_i,
  // sample items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hcc_pkg::InDataW-1:0]     s_axis_tdata,  // temperature[11:0], now_ms[43:12]
  input  logic                            s_axis_tuser,  // func
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cooling[0], command[2:1], setpoint[7:3], total_run_ms[39:8],
  // total_off_ms[71:40], cycle_count[103:72], max_temp[115:104], min_temp[127:116]
  output logic [hcc_pkg::OutDataW-1:0]    m_axis_tdata
);

  hcc_pkg::cfg_t    cfg;
  hcc_pkg::item_t   in_q;
  hcc_pkg::result_t result;
  hcc_pkg::result_t res_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;

  hcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // item moves into the result register when that slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.func        <= s_axis_tuser;
      in_q.temperature <= s_axis_tdata[11:0];
      in_q.now_ms      <= s_axis_tdata[43:12];
    end
  end

  hcc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

/* hdl/hcc_checker.sv */
// ----------------------------------------------------------------------------
// hcc_checker
// Port-level checks on the result stream of the cooling controller.
// ----------------------------------------------------------------------------
module hcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [hcc_pkg::OutDataW-1:0] m_axis_tdata
);

  // a start command always leaves the cooler running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:1] == hcc_pkg::CMD_START)) |-> m_axis_tdata[0])
    else $error("start command with cooler off");

  // an off command always leaves the cooler stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:1] == hcc_pkg::CMD_OFF)) |-> !m_axis_tdata[0])
    else $error("off command with cooler running");

  // setpoint only travels with a start command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:1] != hcc_pkg::CMD_START)) |-> (m_axis_tdata[7:3] == '0))
    else $error("setpoint without start");

  // minimum statistic only ever holds a positive value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[127:116]) > 12'sd0))
    else $error("minimum temperature not positive");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

bind hysteresis_cooling_controller_core hcc_checker u_hcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hysteresis cooling controller core. Sample and
// clear items go in on the slave stream while a local thermostat predictor
// works out each expected result item; every result leaving the master stream
// is checked field by field against the oldest prediction. Short directed
// tests come first, then random sequences under several register settings,
// with random gaps on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import hcc_pkg::*;

  localparam int WatchdogCycles = 2000;
  localparam int LongHoldCycles = 150;
  localparam int MaxReports     = 40;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block ports
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // temperature[11:0], now_ms[43:12]
  logic                s_axis_tuser  = 1'b0;  // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // cooling[0], command[2:1], setpoint[7:3], total_run_ms[39:8],
  // total_off_ms[71:40], cycle_count[103:72], max_temp[115:104], min_temp[127:116]
  logic [OutDataW-1:0] m_axis_tdata;

  // predicted thermostat state and register copy
  cfg_t                    cfg_shadow;
  logic                    th_cooling;
  logic [TimeW-1:0]        th_last_change;
  logic [TimeW-1:0]        th_run_sum;
  logic [TimeW-1:0]        th_off_sum;
  logic [TimeW-1:0]        th_cycles;
  logic signed [TempW-1:0] th_highest;
  logic signed [TempW-1:0] th_lowest;
  result_t                 pending_results[$];

  // run bookkeeping
  logic [TimeW-1:0] clock_ms = '0;
  logic             src_idle_on = 1'b1;
  logic             sink_idle_on = 1'b1;
  logic             long_hold_req = 1'b0;
  int               mismatch_count = 0;
  int               items_sent = 0;
  int               clears_sent = 0;
  int               results_checked = 0;
  int               starts_seen = 0;
  int               stops_seen = 0;
  int               quiet_cycles = 0;
  result_t          seen_result;
  result_t          want_result;

  hysteresis_cooling_controller_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // thermostat predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_statistics();
    th_run_sum = '0;
    th_off_sum = '0;
    th_cycles  = '0;
    th_highest = StatMaxNone;
    th_lowest  = StatMinNone;
  endfunction

  function automatic void reset_thermostat();
    cfg_shadow.target_temp     = 9'd240;
    cfg_shadow.hysteresis      = 6'd10;
    cfg_shadow.min_run_ms      = 32'd300000;
    cfg_shadow.min_off_ms      = 32'd180000;
    cfg_shadow.enable          = 1'b1;
    cfg_shadow.manual_override = 1'b0;
    th_cooling     = 1'b0;
    th_last_change = '0;
    clear_statistics();
  endfunction

  // book the time spent in the state being left, then switch
  function automatic void change_state(logic to_cooling, logic [TimeW-1:0] now);
    logic [TimeW-1:0] spent;
    spent = now - th_last_change;
    if (th_cooling) begin
      th_run_sum = th_run_sum + spent;
      th_cycles  = th_cycles + 1;
    end else begin
      th_off_sum = th_off_sum + spent;
    end
    th_cooling     = to_cooling;
    th_last_change = now;
  endfunction

  function automatic result_t thermostat_step(logic func, logic signed [TempW-1:0] temp,
                                              logic [TimeW-1:0] now);
    result_t          res;
    logic [TimeW-1:0] elapsed;
    int               upper;
    int               lower;
    int               sp;
    res = '0;
    res.command = CMD_NONE;
    if (func == FUNC_CLEAR) begin
      clear_statistics();
    end else begin
      // extremes: zero takes part in the maximum only
      if (temp > th_highest) th_highest = temp;
      if (temp < th_lowest && temp > 0) th_lowest = temp;
      if (cfg_shadow.enable && !cfg_shadow.manual_override && temp != 0) begin
        elapsed = now - th_last_change;
        upper = int'(cfg_shadow.target_temp) + int'(cfg_shadow.hysteresis);
        lower = int'(cfg_shadow.target_temp) - int'(cfg_shadow.hysteresis);
        if (int'(temp) > upper) begin
          if (!th_cooling && elapsed >= cfg_shadow.min_off_ms) begin
            change_state(1'b1, now);
            res.command = CMD_START;
            sp = int'(cfg_shadow.target_temp) / 10;
            if (sp < int'(SetLow)) sp = int'(SetLow);
            if (sp > int'(SetHigh)) sp = int'(SetHigh);
            res.setpoint = SetW'(sp);
          end
        end else if (int'(temp) < lower) begin
          if (th_cooling && elapsed >= cfg_shadow.min_run_ms) begin
            change_state(1'b0, now);
            res.command = CMD_OFF;
          end
        end
      end
    end
    res.cooling      = th_cooling;
    res.total_run_ms = th_run_sum;
    res.total_off_ms = th_off_sum;
    res.cycle_count  = th_cycles;
    res.max_temp     = th_highest;
    res.min_temp     = th_lowest;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item, with an optional idle burst first, and predict its result
  task automatic send_item(logic func, logic signed [TempW-1:0] temp, logic [TimeW-1:0] now);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= InDataW'({now, temp});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(thermostat_step(func, temp, now));
    items_sent++;
    if (func == FUNC_CLEAR) clears_sent++;
  endtask

  task automatic send_sample(logic signed [TempW-1:0] temp, logic [TimeW-1:0] now);
    send_item(FUNC_SAMPLE, temp, now);
    clock_ms = now;
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARGET_TEMP: cfg_shadow.target_temp     = value[8:0];
      CFG_HYSTERESIS:  cfg_shadow.hysteresis      = value[5:0];
      CFG_MIN_RUN_MS:  cfg_shadow.min_run_ms      = value;
      CFG_MIN_OFF_MS:  cfg_shadow.min_off_ms      = value;
      CFG_ENABLE:      cfg_shadow.enable          = value[0];
      CFG_MANUAL:      cfg_shadow.manual_override = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CfgDataW-1:0] target, logic [CfgDataW-1:0] hyst,
                            logic [CfgDataW-1:0] min_run, logic [CfgDataW-1:0] min_off,
                            logic en, logic manual);
    drain_results();
    write_reg(CFG_TARGET_TEMP, target);
    write_reg(CFG_HYSTERESIS, hyst);
    write_reg(CFG_MIN_RUN_MS, min_run);
    write_reg(CFG_MIN_OFF_MS, min_off);
    write_reg(CFG_ENABLE, CfgDataW'(en));
    write_reg(CFG_MANUAL, CfgDataW'(manual));
  endtask

  // mostly plausible room readings around the deadband, plus clears, zero readings and noise
  task automatic run_random(int count);
    int                      pick;
    int                      span;
    int                      t;
    logic [TimeW-1:0]        hold_max;
    logic [TimeW-1:0]        step_max;
    logic signed [TempW-1:0] temp;
    logic [TimeW-1:0]        now;
    for (int n = 0; n < count; n++) begin
      hold_max = (cfg_shadow.min_run_ms > cfg_shadow.min_off_ms) ?
                 cfg_shadow.min_run_ms : cfg_shadow.min_off_ms;
      step_max = (hold_max / 4) * 3 + 32'd1000;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(FUNC_CLEAR, TempW'($urandom()), $urandom());
      end else if (pick < 8) begin
        send_sample('0, clock_ms + $urandom_range(0, step_max));
      end else if (pick < 20) begin
        // noise: any reading, any time, including backwards steps
        temp = TempW'($urandom());
        case ($urandom_range(0, 2))
          0:       now = $urandom();
          1:       now = th_last_change - 1;
          default: now = clock_ms - $urandom_range(0, 5000);
        endcase
        send_sample(temp, now);
      end else begin
        span = 2 * int'(cfg_shadow.hysteresis) + 15;
        t = int'(cfg_shadow.target_temp) + int'($urandom_range(0, 2 * span)) - span;
        send_sample(TempW'(t), clock_ms + $urandom_range(0, step_max));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero reading and the extremes of the temperature field, cooler still off
  task automatic test_reset_and_extremes();
    send_sample('0, 32'd0);
    send_sample(12'sh800, 32'd1000);
    send_sample(12'sh7ff, 32'd2000);
    send_sample(12'sd1, 32'd3000);
    send_sample(-12'sd400, 32'd4000);
    send_sample(12'sd1250, 32'd5000);
  endtask

  // start and stop exactly at the minimum off and run times
  task automatic test_start_and_stop();
    send_sample(12'sd251, 32'd179999);
    send_sample(12'sd251, 32'd180000);
    send_sample(12'sd250, 32'd300000);
    send_sample(12'sd229, 32'd479999);
    send_sample(12'sd229, 32'd480000);
  endtask

  // a timestamp one behind the last change gives the largest elapsed time
  task automatic test_backward_time();
    send_sample(12'sd260, th_last_change - 1);
  endtask

  task automatic test_clear();
    send_item(FUNC_CLEAR, TempW'($urandom()), $urandom());
    send_sample(12'sd240, 32'd600000);
  endtask

  // disabled and manual modes keep statistics but make no decision
  task automatic test_gating();
    drain_results();
    write_reg(CFG_ENABLE, '0);
    send_sample(12'sd100, 32'd5000000);
    drain_results();
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_MANUAL, 32'd1);
    send_sample(12'sd100, 32'd5050000);
    drain_results();
    write_reg(CFG_MANUAL, '0);
    send_sample(12'sd100, 32'd5100000);
  endtask

  // setpoint clamping and truncation; upper data bits beyond a register are dropped
  task automatic test_setpoint_clamp();
    drain_results();
    write_reg(CFG_TARGET_TEMP, {23'h7fffff, 9'd100});
    write_reg(CFG_HYSTERESIS, 32'hffff_ffc5);
    send_sample(12'sd200, 32'd6000000);
    drain_results();
    write_reg(CFG_TARGET_TEMP, 32'hffff_ffff);
    write_reg(CFG_HYSTERESIS, 32'hffff_ffff);
    send_sample(12'sd100, 32'd7000000);
    send_sample(12'sd600, 32'd8000000);
    drain_results();
    write_reg(CFG_TARGET_TEMP, 32'd259);
    write_reg(CFG_HYSTERESIS, 32'd5);
    send_sample(12'sd100, 32'd9000000);
    send_sample(12'sd300, 32'd10000000);
    drain_results();
    write_reg(CFG_TARGET_TEMP, 32'd240);
    write_reg(CFG_HYSTERESIS, 32'd10);
  endtask

  // writes to unused register indexes change nothing
  task automatic test_spare_index();
    for (int i = int'(CFG_MANUAL) + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), 32'hffff_ffff);
    end
    send_sample(12'sd100, 32'd11000000);
  endtask

  task automatic test_random_defaults();
    set_config(32'd240, 32'd10, 32'd300000, 32'd180000, 1'b1, 1'b0);
    run_random(140);
    // sender pauses until the block has emptied
    drain_results();
    run_random(140);
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    drain_results();
    src_idle_on   = 1'b0;
    long_hold_req = 1'b1;
    run_random(40);
    drain_results();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    set_config(32'd160, 32'd5, '0, '0, 1'b1, 1'b0);
    run_random(150);
    set_config(32'd300, 32'd50, 32'd1000, 32'd2000, 1'b1, 1'b0);
    run_random(150);
    set_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    run_random(100);
    set_config('0, '0, 32'd5000, '0, 1'b1, 1'b0);
    run_random(100);
    set_config(32'd240, 32'd10, 32'd20000, 32'd20000, 1'b0, 1'b0);
    run_random(50);
    set_config(32'd240, 32'd10, 32'd20000, 32'd20000, 1'b1, 1'b1);
    run_random(50);
  endtask

  // last stretch at full rate on both streams
  task automatic test_random_no_idle();
    set_config(32'd250, 32'd20, 32'd60000, 32'd40000, 1'b1, 1'b0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_random(200);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // ready pattern: random stall bursts, or one long hold-off when asked
  always begin
    @(negedge clk_i);
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (LongHoldCycles - 1) @(negedge clk_i);
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < MaxReports) begin
      $display("mismatch at result %0d, %s: got %0d, expected %0d",
               results_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending, command", seen_result.command, 0);
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.cooling !== want_result.cooling)
          report_mismatch("cooling", seen_result.cooling, want_result.cooling);
        if (seen_result.command !== want_result.command)
          report_mismatch("command", seen_result.command, want_result.command);
        if (seen_result.setpoint !== want_result.setpoint)
          report_mismatch("setpoint", seen_result.setpoint, want_result.setpoint);
        if (seen_result.total_run_ms !== want_result.total_run_ms)
          report_mismatch("total_run_ms", seen_result.total_run_ms, want_result.total_run_ms);
        if (seen_result.total_off_ms !== want_result.total_off_ms)
          report_mismatch("total_off_ms", seen_result.total_off_ms, want_result.total_off_ms);
        if (seen_result.cycle_count !== want_result.cycle_count)
          report_mismatch("cycle_count", seen_result.cycle_count, want_result.cycle_count);
        if (seen_result.max_temp !== want_result.max_temp)
          report_mismatch("max_temp", seen_result.max_temp, want_result.max_temp);
        if (seen_result.min_temp !== want_result.min_temp)
          report_mismatch("min_temp", seen_result.min_temp, want_result.min_temp);
        if (want_result.command == CMD_START) starts_seen++;
        if (want_result.command == CMD_OFF) stops_seen++;
      end
      results_checked++;
    end
  end

  // ends the run when no item moves on either stream for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogCycles) begin
      $display("no item moved for %0d cycles, %0d results still due",
               WatchdogCycles, pending_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_thermostat();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_and_extremes();
    test_start_and_stop();
    test_backward_time();
    test_clear();
    test_gating();
    test_setpoint_clamp();
    test_spare_index();
    test_random_defaults();
    test_backpressure();
    test_random_settings();
    test_random_no_idle();
    drain_results();

    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_results.size());
    end
    $display("sent %0d items (%0d clears), checked %0d results: %0d starts, %0d stops",
             items_sent, clears_sent, results_checked, starts_seen, stops_seen);
    $display("settings covered: defaults, narrow and widest deadbands, zero and full hold"
             , " times, disabled and manual modes, long receiver stall");
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/hcc_pkg.sv
hdl/hcc_cfg_regs.sv
hdl/hcc_ctrl.sv
hdl/hysteresis_cooling_controller_core.sv
hdl/hcc_checker.sv
sim/testbench.sv
